FILE: hdl/ucfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucfp_pkg;

  // Input item: a received byte or a key-press event
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  // One byte of an outgoing frame, with the LED and blink state after its item
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       led_on;
    logic [8:0] blink_total;
  } out_t;

  typedef struct packed {
    logic [7:0] rx_head_first;
    logic [7:0] rx_head_second;
    logic [7:0] rx_tail_first;
    logic [7:0] rx_tail_second;
    logic [7:0] resp_head_first;
    logic [7:0] resp_head_second;
    logic [7:0] resp_tail_first;
    logic [7:0] resp_tail_second;
  } cfg_t;

  // Frame job handed from the parser to the serialiser
  typedef struct packed {
    logic       is_key;
    logic [7:0] data;
    logic       led;
    logic [8:0] blink;
  } job_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RX_HEAD_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_HEAD_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TAIL_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TAIL_SECOND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_HEAD_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_HEAD_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_TAIL_FIRST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_TAIL_SECOND = 3'd7;

  localparam cfg_t CFG_RESET = '{
    rx_head_first:    8'hAA,
    rx_head_second:   8'h55,
    rx_tail_first:    8'h0D,
    rx_tail_second:   8'h0A,
    resp_head_first:  8'hBB,
    resp_head_second: 8'h66,
    resp_tail_first:  8'h0D,
    resp_tail_second: 8'h0A
  };

  localparam logic [7:0] CMD_LED   = 8'h01;
  localparam logic [7:0] CMD_BLINK = 8'h02;
  localparam logic [7:0] DATA_ZERO = 8'h00;
  localparam logic [7:0] DATA_ONE  = 8'h01;
  localparam logic [7:0] ACK_BYTE  = 8'h00;

  // Byte positions within a seven-byte frame
  localparam logic [2:0] BYTE_HEAD_FIRST  = 3'd0;
  localparam logic [2:0] BYTE_HEAD_SECOND = 3'd1;
  localparam logic [2:0] BYTE_CMD         = 3'd2;
  localparam logic [2:0] BYTE_DATA        = 3'd3;
  localparam logic [2:0] BYTE_SUM         = 3'd4;
  localparam logic [2:0] BYTE_TAIL_FIRST  = 3'd5;
  localparam logic [2:0] BYTE_TAIL_SECOND = 3'd6;

endpackage

`default_nettype wire

FILE: hdl/uart_command_frame_parser_responder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake               Payload
// ---------  ----------------------  -------------------------------------------
// input      push / full             in_i  : kind, rx_byte
// result     empty / pop             out_o : tx_byte, tx_last, led_on, blink_total
// config     cfg_we_i, cfg_idx_i     cfg_wdata_i, eight 8-bit registers
//
// One input item is taken per cycle while full is low; each completed frame or key
// press queues a job and the serialiser sends its seven bytes at one byte per cycle
// while the result queue has room. The job is registered in the job queue and each
// byte in the result queue before it is on the result ports.
// full rises only when the job queue is full, e.g. under a burst of key presses,
// since the serialiser sends seven bytes for each job.
// Reset is asynchronous; all queues empty and registers take their defaults.

module uart_command_frame_parser_responder_top #(
  parameter int unsigned JOB_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire ucfp_pkg::in_t                 in_i,
  output logic                               empty,
  input  wire logic                          pop,
  output ucfp_pkg::out_t                     out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ucfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ucfp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ucfp_pkg::cfg_t cfg_q;
  ucfp_pkg::job_t job_in, job_out;
  logic           job_push, job_pop, job_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ucfp_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ucfp_pkg::CFG_RX_HEAD_FIRST:    cfg_q.rx_head_first    <= cfg_wdata_i;
        ucfp_pkg::CFG_RX_HEAD_SECOND:   cfg_q.rx_head_second   <= cfg_wdata_i;
        ucfp_pkg::CFG_RX_TAIL_FIRST:    cfg_q.rx_tail_first    <= cfg_wdata_i;
        ucfp_pkg::CFG_RX_TAIL_SECOND:   cfg_q.rx_tail_second   <= cfg_wdata_i;
        ucfp_pkg::CFG_RESP_HEAD_FIRST:  cfg_q.resp_head_first  <= cfg_wdata_i;
        ucfp_pkg::CFG_RESP_HEAD_SECOND: cfg_q.resp_head_second <= cfg_wdata_i;
        ucfp_pkg::CFG_RESP_TAIL_FIRST:  cfg_q.resp_tail_first  <= cfg_wdata_i;
        ucfp_pkg::CFG_RESP_TAIL_SECOND: cfg_q.resp_tail_second <= cfg_wdata_i;
      endcase
    end
  end

  ucfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .job_full_i (full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  ucfp_fifo #(
    .T     (ucfp_pkg::job_t),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  ucfp_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: hdl/ucfp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ucfp_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ucfp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ucfp_pkg::in_t in_i,
  input  wire ucfp_pkg::cfg_t cfg_i,
  input  wire logic          job_full_i,
  output logic               job_push_o,
  output ucfp_pkg::job_t     job_o
);

  typedef enum logic [6:0] {
    POS_HEAD1 = 7'b0000001,
    POS_HEAD2 = 7'b0000010,
    POS_CMD   = 7'b0000100,
    POS_DATA  = 7'b0001000,
    POS_SUM   = 7'b0010000,
    POS_TAIL1 = 7'b0100000,
    POS_TAIL2 = 7'b1000000
  } pos_e;

  pos_e       pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic       cmd_blink_q, cmd_blink_d;   // held command: 0 = LED, 1 = blink
  logic [7:0] payload_q, payload_d;
  logic       led_q, led_d;
  logic [8:0] blink_q, blink_d;
  logic       toggle_q, toggle_d;
  logic       accept;
  logic       ok;
  logic [7:0] b;

  assign accept = push_i && !job_full_i;
  assign b      = in_i.rx_byte;

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    cmd_blink_d = cmd_blink_q;
    payload_d   = payload_q;
    led_d       = led_q;
    blink_d     = blink_q;
    toggle_d    = toggle_q;
    ok          = 1'b0;
    job_push_o  = 1'b0;
    job_o       = '{is_key: 1'b0, data: ucfp_pkg::DATA_ZERO, led: led_q, blink: blink_q};
    if (accept) begin
      if (in_i.kind) begin
        // key press leaves the parser alone
        job_push_o   = 1'b1;
        job_o.is_key = 1'b1;
        job_o.data   = toggle_q ? ucfp_pkg::DATA_ZERO : ucfp_pkg::DATA_ONE;
        toggle_d     = ~toggle_q;
      end else begin
        unique case (pos_q)
          POS_HEAD1: begin
            if (b == cfg_i.rx_head_first) begin
              sum_d = b;
              pos_d = POS_HEAD2;
            end
          end
          POS_HEAD2: begin
            if (b == cfg_i.rx_head_second) begin
              sum_d = sum_q + b;
              pos_d = POS_CMD;
            end else begin
              pos_d = POS_HEAD1;
            end
          end
          POS_CMD: begin
            if (b == ucfp_pkg::CMD_LED || b == ucfp_pkg::CMD_BLINK) begin
              cmd_blink_d = (b == ucfp_pkg::CMD_BLINK);
              sum_d       = sum_q + b;
              pos_d       = POS_DATA;
            end else begin
              pos_d = POS_HEAD1;
            end
          end
          POS_DATA: begin
            payload_d = b;
            sum_d     = sum_q + b;
            pos_d     = POS_SUM;
          end
          POS_SUM:   pos_d = (b == sum_q) ? POS_TAIL1 : POS_HEAD1;
          POS_TAIL1: pos_d = (b == cfg_i.rx_tail_first) ? POS_TAIL2 : POS_HEAD1;
          POS_TAIL2: begin
            pos_d = POS_HEAD1;
            if (b == cfg_i.rx_tail_second) begin
              if (cmd_blink_q) begin
                blink_d = {payload_q, 1'b0};
                ok      = 1'b1;
              end else if (payload_q == ucfp_pkg::DATA_ZERO ||
                           payload_q == ucfp_pkg::DATA_ONE) begin
                led_d = payload_q[0];
                ok    = 1'b1;
              end
              job_push_o = 1'b1;
              job_o.data = {7'b0, ok};
              job_o.led  = led_d;
              job_o.blink = blink_d;
            end
          end
          default: pos_d = POS_HEAD1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HEAD1;
      sum_q       <= '0;
      cmd_blink_q <= 1'b0;
      payload_q   <= '0;
      led_q       <= 1'b0;
      blink_q     <= '0;
      toggle_q    <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      cmd_blink_q <= cmd_blink_d;
      payload_q   <= payload_d;
      led_q       <= led_d;
      blink_q     <= blink_d;
      toggle_q    <= toggle_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ucfp_back #(
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ucfp_pkg::cfg_t cfg_i,
  input  wire ucfp_pkg::job_t job_i,
  input  wire logic           job_empty_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output ucfp_pkg::out_t      out_o
);

  logic [2:0]     idx_q, idx_d;
  logic           out_full;
  logic           emit;
  logic [7:0]     h0, h1, f2, t0, t1, sum;
  ucfp_pkg::out_t beat;

  assign emit      = !job_empty_i && !out_full;
  assign job_pop_o = emit && (idx_q == ucfp_pkg::BYTE_TAIL_SECOND);

  assign h0  = job_i.is_key ? cfg_i.rx_head_first  : cfg_i.resp_head_first;
  assign h1  = job_i.is_key ? cfg_i.rx_head_second : cfg_i.resp_head_second;
  assign t0  = job_i.is_key ? cfg_i.rx_tail_first  : cfg_i.resp_tail_first;
  assign t1  = job_i.is_key ? cfg_i.rx_tail_second : cfg_i.resp_tail_second;
  assign f2  = job_i.is_key ? ucfp_pkg::CMD_LED    : ucfp_pkg::ACK_BYTE;
  assign sum = h0 + h1 + f2 + job_i.data;

  always_comb begin
    beat.tx_last     = (idx_q == ucfp_pkg::BYTE_TAIL_SECOND);
    beat.led_on      = job_i.led;
    beat.blink_total = job_i.blink;
    case (idx_q)
      ucfp_pkg::BYTE_HEAD_FIRST:  beat.tx_byte = h0;
      ucfp_pkg::BYTE_HEAD_SECOND: beat.tx_byte = h1;
      ucfp_pkg::BYTE_CMD:         beat.tx_byte = f2;
      ucfp_pkg::BYTE_DATA:        beat.tx_byte = job_i.data;
      ucfp_pkg::BYTE_SUM:         beat.tx_byte = sum;
      ucfp_pkg::BYTE_TAIL_FIRST:  beat.tx_byte = t0;
      default:                    beat.tx_byte = t1;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = job_pop_o ? ucfp_pkg::BYTE_HEAD_FIRST : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= ucfp_pkg::BYTE_HEAD_FIRST;
    end else begin
      idx_q <= idx_d;
    end
  end

  ucfp_fifo #(
    .T     (ucfp_pkg::out_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (beat),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

FILE: hdl/ucfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ucfp_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           empty,
  input wire logic           pop,
  input wire ucfp_pkg::out_t out_o
);

  logic       take;
  logic [2:0] pos_q;
  logic [7:0] sum_q;
  logic       led_q;
  logic [8:0] blink_q;

  assign take = pop && !empty;

  // shadow of the outgoing frame position and running checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= ucfp_pkg::BYTE_HEAD_FIRST;
      sum_q   <= '0;
      led_q   <= 1'b0;
      blink_q <= '0;
    end else if (take) begin
      pos_q   <= (pos_q == ucfp_pkg::BYTE_TAIL_SECOND) ? ucfp_pkg::BYTE_HEAD_FIRST
                                                       : pos_q + 3'd1;
      sum_q   <= (pos_q == ucfp_pkg::BYTE_HEAD_FIRST) ? out_o.tx_byte
                                                      : sum_q + out_o.tx_byte;
      led_q   <= out_o.led_on;
      blink_q <= out_o.blink_total;
    end
  end

  a_last_on_seventh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (out_o.tx_last == (pos_q == ucfp_pkg::BYTE_TAIL_SECOND)))
    else $error("tx_last out of step with frame position");

  a_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (pos_q == ucfp_pkg::BYTE_SUM) |-> (out_o.tx_byte == sum_q))
    else $error("checksum byte does not match preceding bytes");

  a_state_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (pos_q != ucfp_pkg::BYTE_HEAD_FIRST) |->
      (out_o.led_on == led_q) && (out_o.blink_total == blink_q))
    else $error("LED or blink state changed within a frame");

  a_blink_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.blink_total[0] == 1'b0))
    else $error("odd blink count");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("waiting result dropped or changed");

endmodule

bind uart_command_frame_parser_responder_top ucfp_checker u_ucfp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

`default_nettype wire

FILE: dv/uart_command_frame_parser_responder_top_test.sv
`timescale 1ns / 1ps

module uart_command_frame_parser_responder_top_test;
  import ucfp_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int ITEMS_PER_PHASE = 87;
  localparam int PHASES          = 5;
  localparam int SETTLE_CYCLES   = 12;
  localparam int IDLE_PCT        = 26;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;
  localparam int NO_POS          = 7;

  // Tracks the parser and LED/blink state and holds the bytes still owed on the tx side
  class frame_scoreboard;
    cfg_t        regs;
    logic [2:0]  pos;
    logic [7:0]  sum;
    logic [7:0]  cmd;
    logic [7:0]  payload;
    logic        led;
    logic [8:0]  blink;
    logic        key_toggle;
    out_t        tx_bytes_due[$];
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned responses;
    int unsigned key_frames;

    function new();
      regs          = CFG_RESET;
      pos           = BYTE_HEAD_FIRST;
      sum           = '0;
      cmd           = '0;
      payload       = '0;
      led           = 1'b0;
      blink         = '0;
      key_toggle    = 1'b0;
      mismatches    = 0;
      bytes_checked = 0;
      responses     = 0;
      key_frames    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_RX_HEAD_FIRST:    regs.rx_head_first    = v;
        CFG_RX_HEAD_SECOND:   regs.rx_head_second   = v;
        CFG_RX_TAIL_FIRST:    regs.rx_tail_first    = v;
        CFG_RX_TAIL_SECOND:   regs.rx_tail_second   = v;
        CFG_RESP_HEAD_FIRST:  regs.resp_head_first  = v;
        CFG_RESP_HEAD_SECOND: regs.resp_head_second = v;
        CFG_RESP_TAIL_FIRST:  regs.resp_tail_first  = v;
        CFG_RESP_TAIL_SECOND: regs.resp_tail_second = v;
        default: ;
      endcase
    endfunction

    function void queue_frame(logic [7:0] h0, logic [7:0] h1, logic [7:0] op,
                              logic [7:0] d, logic [7:0] t0, logic [7:0] t1);
      logic [7:0] fb [7];
      out_t       o;
      fb[0] = h0;
      fb[1] = h1;
      fb[2] = op;
      fb[3] = d;
      fb[4] = h0 + h1 + op + d;
      fb[5] = t0;
      fb[6] = t1;
      for (int k = 0; k < 7; k++) begin
        o.tx_byte     = fb[k];
        o.tx_last     = (k == 6);
        o.led_on      = led;
        o.blink_total = blink;
        tx_bytes_due.push_back(o);
      end
    endfunction

    function void answer_command();
      logic ok;
      ok = 1'b0;
      if (cmd == CMD_LED) begin
        if (payload == DATA_ZERO || payload == DATA_ONE) begin
          led = payload[0];
          ok  = 1'b1;
        end
      end else if (cmd == CMD_BLINK) begin
        blink = {payload, 1'b0};
        ok    = 1'b1;
      end
      responses++;
      queue_frame(regs.resp_head_first, regs.resp_head_second, ACK_BYTE, {7'd0, ok},
                  regs.resp_tail_first, regs.resp_tail_second);
    endfunction

    function void take_item(in_t it);
      logic [7:0] b;
      b = it.rx_byte;
      if (it.kind) begin
        // key press leaves the parser where it was
        queue_frame(regs.rx_head_first, regs.rx_head_second, CMD_LED,
                    key_toggle ? DATA_ZERO : DATA_ONE, regs.rx_tail_first, regs.rx_tail_second);
        key_toggle = ~key_toggle;
        key_frames++;
        return;
      end
      case (pos)
        BYTE_HEAD_FIRST: begin
          if (b == regs.rx_head_first) begin
            sum = b;
            pos = BYTE_HEAD_SECOND;
          end
        end
        // a mismatching byte is dropped, not retried as a header
        BYTE_HEAD_SECOND: begin
          if (b == regs.rx_head_second) begin
            sum = sum + b;
            pos = BYTE_CMD;
          end else begin
            pos = BYTE_HEAD_FIRST;
          end
        end
        BYTE_CMD: begin
          if (b == CMD_LED || b == CMD_BLINK) begin
            cmd = b;
            sum = sum + b;
            pos = BYTE_DATA;
          end else begin
            pos = BYTE_HEAD_FIRST;
          end
        end
        BYTE_DATA: begin
          payload = b;
          sum     = sum + b;
          pos     = BYTE_SUM;
        end
        BYTE_SUM:        pos = (b == sum) ? BYTE_TAIL_FIRST : BYTE_HEAD_FIRST;
        BYTE_TAIL_FIRST: pos = (b == regs.rx_tail_first) ? BYTE_TAIL_SECOND : BYTE_HEAD_FIRST;
        BYTE_TAIL_SECOND: begin
          pos = BYTE_HEAD_FIRST;
          if (b == regs.rx_tail_second) answer_command();
        end
        default: pos = BYTE_HEAD_FIRST;
      endcase
    endfunction

    function void check_byte(out_t got);
      out_t want;
      bytes_checked++;
      if (tx_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected tx transaction: byte %h last %b led %b blink %0d",
                   got.tx_byte, got.tx_last, got.led_on, got.blink_total);
        return;
      end
      want = tx_bytes_due.pop_front();
      if (got.tx_byte !== want.tx_byte || got.tx_last !== want.tx_last ||
          got.led_on !== want.led_on || got.blink_total !== want.blink_total) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tx mismatch (exp/got): byte %h/%h last %b/%b led %b/%b blink %0d/%0d",
                   want.tx_byte, got.tx_byte, want.tx_last, got.tx_last,
                   want.led_on, got.led_on, want.blink_total, got.blink_total);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  in_t                   in_i        = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  out_t                  out_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  frame_scoreboard sb = new();
  int unsigned     items_sent   = 0;
  int unsigned     cycle_count  = 0;
  int unsigned     cfg_settings = 0;
  int              idle_pct     = IDLE_PCT;
  int              stall_pct    = IDLE_PCT;

  uart_command_frame_parser_responder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d tx bytes outstanding",
             cycle_count, sb.tx_bytes_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // tx side: sample on the edge, then pick the next pop
  initial begin : tx_sink
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_byte(out_o);
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(input logic k, input logic [7:0] b);
    in_t it;
    it = '{kind: k, rx_byte: b};
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    sb.take_item(it);
    items_sent++;
  endtask

  // bad_pos spoils one byte after the checksum is formed; key_pos slips a key press in
  task automatic send_frame(input logic [7:0] op, input logic [7:0] d,
                            input int bad_pos, input int key_pos);
    logic [7:0] fb [7];
    logic [7:0] v;
    fb[0] = sb.regs.rx_head_first;
    fb[1] = sb.regs.rx_head_second;
    fb[2] = op;
    fb[3] = d;
    fb[4] = fb[0] + fb[1] + op + d;
    fb[5] = sb.regs.rx_tail_first;
    fb[6] = sb.regs.rx_tail_second;
    if (bad_pos == BYTE_CMD) begin
      do v = 8'($urandom); while (v == CMD_LED || v == CMD_BLINK);
      fb[2] = v;
    end else if (bad_pos < NO_POS) begin
      fb[bad_pos] = fb[bad_pos] ^ 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < 7; k++) begin
      if (k == key_pos) send(1'b1, 8'($urandom));
      send(1'b0, fb[k]);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.tx_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic write_config(input cfg_t c);
    wait_idle();
    write_reg(CFG_RX_HEAD_FIRST,    c.rx_head_first);
    write_reg(CFG_RX_HEAD_SECOND,   c.rx_head_second);
    write_reg(CFG_RX_TAIL_FIRST,    c.rx_tail_first);
    write_reg(CFG_RX_TAIL_SECOND,   c.rx_tail_second);
    write_reg(CFG_RESP_HEAD_FIRST,  c.resp_head_first);
    write_reg(CFG_RESP_HEAD_SECOND, c.resp_head_second);
    write_reg(CFG_RESP_TAIL_FIRST,  c.resp_tail_first);
    write_reg(CFG_RESP_TAIL_SECOND, c.resp_tail_second);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_settings++;
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned first;
    int          r;
    logic [7:0]  op;
    logic [7:0]  d;
    first = items_sent;
    while (items_sent - first < n) begin
      r  = $urandom_range(99);
      op = $urandom_range(1) ? CMD_LED : CMD_BLINK;
      case ($urandom_range(3))
        0:       d = DATA_ZERO;
        1:       d = DATA_ONE;
        default: d = 8'($urandom);
      endcase
      if (r < 70) begin
        send_frame(op, d, NO_POS, ($urandom_range(99) < 15) ? $urandom_range(6) : NO_POS);
      end else if (r < 85) begin
        send_frame(op, d, $urandom_range(6), NO_POS);
      end else if (r < 93) begin
        // bursts of key presses back up the job queue
        repeat ($urandom_range(1, 4)) send(1'b1, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send(1'b0, 8'($urandom));
      end
    end
  endtask

  initial begin : main
    cfg_t c;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dropped header byte is not taken as a new header
    send(1'b0, CFG_RESET.rx_head_first);
    send(1'b0, CFG_RESET.rx_head_first);
    send(1'b0, CFG_RESET.rx_head_second);
    send_frame(CMD_LED, DATA_ONE, NO_POS, BYTE_SUM);
    send_frame(CMD_BLINK, 8'hFF, NO_POS, NO_POS);
    send_frame(CMD_LED, 8'h02, NO_POS, NO_POS);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1:       c = '0;
          2:       c = '1;
          3:       c = {$urandom, $urandom};
          default: c = CFG_RESET;
        endcase
        write_config(c);
      end
      idle_pct  = (p == 2) ? 0 : IDLE_PCT;
      stall_pct = idle_pct;
      random_traffic(ITEMS_PER_PHASE);
    end

    wait_idle();
    sb.mismatches += sb.tx_bytes_due.size();
    $display("%0d input items over %0d register settings, %0d command responses, %0d key frames",
             items_sent, cfg_settings + 1, sb.responses, sb.key_frames);
    $display("%0d tx bytes checked, %0d mismatches", sb.bytes_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ucfp_pkg.sv
hdl/ucfp_fifo.sv
hdl/ucfp_front.sv
hdl/ucfp_back.sv
hdl/uart_command_frame_parser_responder_top.sv
hdl/ucfp_checker.sv
dv/uart_command_frame_parser_responder_top_test.sv
